@@ hw/rtl/utf8_stream_decoder_macros.svh @@
// Assertion macros used by the UTF-8 stream decoder top level.
`ifndef UTF8_STREAM_DECODER_MACROS_SVH
`define UTF8_STREAM_DECODER_MACROS_SVH

// Same-cycle implication, checked outside reset
`define U8SD_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("utf8_stream_decoder: same-cycle check failed");

// Next-cycle implication, checked outside reset
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("utf8_stream_decoder: next-cycle check failed");

`endif

@@ hw/rtl/u8sd_pkg.sv @@
// Shared types and constants for the UTF-8 stream decoder.
package u8sd_pkg;

    localparam int unsigned CP_W          = 21;
    localparam int unsigned PARTIAL_W     = 15;
    localparam int unsigned QUEUE_DEPTH   = 4;

    localparam logic [CP_W-1:0] REPLACEMENT_CP = 21'h00FFFD;

    // Byte prefix tags
    localparam logic [1:0] CONT_TAG  = 2'b10;
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Sequence lengths
    localparam logic [2:0] LEN_NONE = 3'd0;
    localparam logic [2:0] LEN_2    = 3'd2;
    localparam logic [2:0] LEN_3    = 3'd3;
    localparam logic [2:0] LEN_4    = 3'd4;

    // One classified byte: rep replacement beats, then an optional tail beat
    typedef struct packed {
        logic [1:0]      rep;
        logic            has_tail;
        logic [CP_W-1:0] tail;
        logic            eos;
    } t_cmd;

endpackage

@@ hw/rtl/u8sd_front.sv @@
// Front end: accepts bytes, tracks the pending sequence and emits beat commands.
module u8sd_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [7:0]        i_data,
    input  logic              i_eos,
    input  logic              i_q_full,
    output logic              o_ready,
    output logic              o_push,
    output u8sd_pkg::t_cmd    o_cmd,
    output logic              o_pending
);

    logic [2:0]                         r_exp_len, n_exp_len;
    logic [1:0]                         r_taken,   n_taken;
    logic [u8sd_pkg::PARTIAL_W-1:0]     r_partial, n_partial;

    logic                               accept;
    logic                               is_cont, is_ascii, is_lead2, is_lead3, is_lead4;
    logic                               is_lead, complete;
    u8sd_pkg::t_cmd                     cmd;

    assign o_ready   = !i_q_full;
    assign accept    = i_valid && o_ready;
    assign o_pending = (r_exp_len != u8sd_pkg::LEN_NONE);

    // Classify the incoming byte
    assign is_cont  = (i_data[7:6] == u8sd_pkg::CONT_TAG);
    assign is_ascii = !i_data[7];
    assign is_lead2 = (i_data[7:5] == u8sd_pkg::LEAD2_TAG);
    assign is_lead3 = (i_data[7:4] == u8sd_pkg::LEAD3_TAG);
    assign is_lead4 = (i_data[7:3] == u8sd_pkg::LEAD4_TAG);
    assign is_lead  = is_lead2 || is_lead3 || is_lead4;
    assign complete = is_cont && (({1'b0, r_taken} + 3'd2) == r_exp_len);

    // Decide the beats for this byte and the next pending state
    always_comb begin
        logic fresh;
        fresh        = 1'b0;
        cmd.rep      = 2'd0;
        cmd.has_tail = 1'b0;
        cmd.tail     = u8sd_pkg::REPLACEMENT_CP;
        cmd.eos      = i_eos;
        n_exp_len    = r_exp_len;
        n_taken      = r_taken;
        n_partial    = r_partial;

        if (o_pending) begin
            if (complete) begin
                cmd.has_tail = 1'b1;
                cmd.tail     = {r_partial, i_data[5:0]};
                n_exp_len    = u8sd_pkg::LEN_NONE;
                n_taken      = 2'd0;
                n_partial    = '0;
            end else if (is_cont && !i_eos) begin
                n_partial = {r_partial[u8sd_pkg::PARTIAL_W-7:0], i_data[5:0]};
                n_taken   = r_taken + 2'd1;
            end else begin
                // Broken sequence: flush lead and taken continuations
                cmd.rep = r_taken + 2'd1;
                fresh   = 1'b1;
            end
        end else begin
            fresh = 1'b1;
        end

        if (fresh) begin
            n_exp_len = u8sd_pkg::LEN_NONE;
            n_taken   = 2'd0;
            n_partial = '0;
            if (is_ascii) begin
                cmd.has_tail = 1'b1;
                cmd.tail     = {13'd0, i_data};
            end else if (is_lead && !i_eos) begin
                priority if (is_lead2) begin
                    n_exp_len = u8sd_pkg::LEN_2;
                    n_partial = {10'd0, i_data[4:0]};
                end else if (is_lead3) begin
                    n_exp_len = u8sd_pkg::LEN_3;
                    n_partial = {11'd0, i_data[3:0]};
                end else begin
                    n_exp_len = u8sd_pkg::LEN_4;
                    n_partial = {12'd0, i_data[2:0]};
                end
            end else begin
                cmd.has_tail = 1'b1;
            end
        end

        // End of string leaves nothing pending
        if (i_eos) begin
            n_exp_len = u8sd_pkg::LEN_NONE;
            n_taken   = 2'd0;
            n_partial = '0;
        end
    end

    assign o_cmd  = cmd;
    assign o_push = accept && ((cmd.rep != 2'd0) || cmd.has_tail);

    // Hold pending state, advance on each accepted beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_exp_len <= u8sd_pkg::LEN_NONE;
            r_taken   <= 2'd0;
            r_partial <= '0;
        end else if (accept) begin
            r_exp_len <= n_exp_len;
            r_taken   <= n_taken;
            r_partial <= n_partial;
        end
    end

endmodule

@@ hw/rtl/u8sd_queue.sv @@
// Command queue between the front end and the beat expander.
module u8sd_queue #(
    parameter int unsigned DEPTH = u8sd_pkg::QUEUE_DEPTH
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  u8sd_pkg::t_cmd    i_cmd,
    output logic              o_full,
    input  logic              i_pop,
    output logic              o_valid,
    output u8sd_pkg::t_cmd    o_cmd
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8sd_pkg::t_cmd  r_mem [DEPTH];
    logic [AW-1:0]   r_wr, n_wr, r_rd, n_rd;
    logic [CW-1:0]   r_count, n_count;
    logic            do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_valid = (r_count != '0);
    assign o_cmd   = r_mem[r_rd];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && o_valid;

    // Advance pointers with wrap at the depth
    always_comb begin
        n_wr    = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + AW'(1);
        n_rd    = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + AW'(1);
        n_count = r_count;
        if (do_push && !do_pop) begin
            n_count = r_count + CW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= n_wr;
            if (do_pop)  r_rd <= n_rd;
            r_count <= n_count;
        end
    end

    // Store entries; no reset needed on payload
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

@@ hw/rtl/u8sd_back.sv @@
// Back end: expands each command into output beats from a holding register.
module u8sd_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_q_valid,
    input  u8sd_pkg::t_cmd              i_q_cmd,
    output logic                        o_q_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [u8sd_pkg::CP_W-1:0]   o_cp,
    output logic                        o_last_item,
    output logic                        o_done
);

    logic            r_busy;
    u8sd_pkg::t_cmd  r_cmd;
    logic [1:0]      r_idx;
    logic            at_tail, last, beat;

    assign at_tail = (r_idx == r_cmd.rep);
    assign last    = at_tail || (!r_cmd.has_tail && ((r_idx + 2'd1) == r_cmd.rep));
    assign beat    = r_busy && i_ready;
    assign o_q_pop = i_q_valid && (!r_busy || (beat && last));

    // Drive the current beat from the held command
    assign o_valid     = r_busy;
    assign o_cp        = at_tail ? r_cmd.tail : u8sd_pkg::REPLACEMENT_CP;
    assign o_last_item = last;
    assign o_done      = last && r_cmd.eos;

    // Load the next command or advance within the current one
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_idx  <= 2'd0;
        end else if (o_q_pop) begin
            r_busy <= 1'b1;
            r_idx  <= 2'd0;
        end else if (beat) begin
            if (last) begin
                r_busy <= 1'b0;
            end else begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_cmd <= i_q_cmd;
        end
    end

endmodule

@@ hw/rtl/utf8_stream_decoder.sv @@
// Top level of the UTF-8 stream decoder.
//
// Slave stream: one byte per beat on i_s_tdata, i_s_tlast marks the final
// byte of a string. Master stream: one code point per beat on o_m_tdata,
// o_m_tuser flags the final code point caused by one input byte, o_m_tlast
// flags the final code point of the string.
// A byte is classified in the cycle it is accepted and its beats are queued;
// its command passes through the queue and the holding register before the
// first beat is offered. Each byte yields zero to four beats (four only for
// a 4-byte sequence broken after two continuations: three replacements and
// then the breaking byte); the expander sends one beat per cycle while the
// receiver is ready, so valid text runs at one byte per cycle. The command
// queue depth (QUEUE_DEPTH entries) absorbs replacement bursts.
// When the receiver stalls, the current beat holds and the queue fills;
// o_s_tready drops only once the queue is full.
// Synchronous active-low reset empties the queue, drops any pending sequence
// and clears o_m_tvalid; no beat is lost or repeated across stalls.
module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = u8sd_pkg::QUEUE_DEPTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  logic        i_s_tlast,   // end_of_string
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [23:0] o_m_tdata,   // [20:0] code_point, [23:21] zero
    output logic        o_m_tuser,   // [0] last_for_item
    output logic        o_m_tlast    // string_done
);

    `include "utf8_stream_decoder_macros.svh"

    u8sd_pkg::t_cmd               front_cmd, queue_cmd;
    logic                         front_push, q_full, q_pop, q_valid, pending;
    logic [u8sd_pkg::CP_W-1:0]    cp;

    u8sd_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .i_data    (i_s_tdata),
        .i_eos     (i_s_tlast),
        .i_q_full  (q_full),
        .o_ready   (o_s_tready),
        .o_push    (front_push),
        .o_cmd     (front_cmd),
        .o_pending (pending)
    );

    u8sd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (front_push),
        .i_cmd   (front_cmd),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_valid (q_valid),
        .o_cmd   (queue_cmd)
    );

    u8sd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_q_cmd     (queue_cmd),
        .o_q_pop     (q_pop),
        .o_valid     (o_m_tvalid),
        .i_ready     (i_m_tready),
        .o_cp        (cp),
        .o_last_item (o_m_tuser),
        .o_done      (o_m_tlast)
    );

    assign o_m_tdata = {3'd0, cp};

    // A push never lands on a full queue
    `U8SD_ASSERT_NOW(a_no_overflow, i_clk, i_rst_n, front_push, !q_full)
    // String end leaves no sequence pending
    `U8SD_ASSERT_NEXT(a_eos_clears, i_clk, i_rst_n, i_s_tvalid && o_s_tready && i_s_tlast, !pending)
    // String end only on the final beat of a byte
    `U8SD_ASSERT_NOW(a_done_is_last, i_clk, i_rst_n, o_m_tvalid && o_m_tlast, o_m_tuser)

endmodule
